// ===== src/rcbd_pkg.sv =====
// Shared constants and command/status types of the column run-length bitmap decoder.
package rcbd_pkg;

  localparam int MAX_ROWS    = 128;
  localparam int MAX_COLUMNS = 2048;
  localparam int MAX_CHARS   = MAX_ROWS / 8;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int GRP_W       = ROW_W - 3;

  localparam logic [1:0] REG_IMAGE_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_HEIGHT_IN_CHARS = 2'd1;
  localparam logic [1:0] REG_BASE_ADDRESS    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic load;  // take the code byte presented on the input channel
    logic step;  // expand one chunk of the run
  } cmd_t;

  typedef struct packed {
    logic starts_run;  // the byte being loaded begins a run
    logic can_step;    // output register free for a new group
    logic last_chunk;  // this chunk ends the run or the image
  } sts_t;

endpackage

// ===== src/rcbd_ctrl.sv =====
// Controller state machine: sequences byte loads and run expansion.
module rcbd_ctrl import rcbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.starts_run) state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.can_step) begin
          cmd.step = 1'b1;
          if (sts.last_chunk) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== src/rcbd_dp.sv =====
// Datapath: configuration, run state, color strip, group assembly and output register.
module rcbd_dp import rcbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic [7:0]  in_code_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_group_address,
  output logic [31:0] out_group_pixels,
  output logic [10:0] out_column_index,
  output logic [3:0]  out_char_row,
  output logic        out_image_done,
  output logic        out_last_of_item
);

  logic [11:0] cols_cfg_r;
  logic [4:0]  chars_cfg_r;
  logic [19:0] base_r;

  logic [31:0] strip_r [MAX_CHARS];

  logic [8:0]       run_r, run_nxt;
  logic [3:0]       color_r;
  logic             keep_r;
  logic             await_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [10:0]      col_r, col_nxt;

  logic        out_valid_r;
  logic [20:0] addr_r;
  logic [31:0] pix_r;
  logic [10:0] colidx_r;
  logic [3:0]  crow_r;
  logic        done_r;
  logic        last_r;

  logic [11:0] eff_cols;
  logic [4:0]  eff_chars;
  logic [2:0]  ofs;
  logic [3:0]  space;
  logic [3:0]  chunk;
  logic [3:0]  ofs_end;
  logic [8:0]  run_after;
  logic [ROW_W:0] row_sum;
  logic [GRP_W-1:0] grp;
  logic [31:0] old_word, new_word;
  logic        boundary, col_end, img_done;
  logic [11:0] col_inc;
  logic [12:0] col_chars;
  logic [20:0] grp_addr;
  logic [2:0]  cnt3;
  logic [6:0]  cnt7;
  logic        can_step;

  always_comb begin
    if (cols_cfg_r == 12'd0 || cols_cfg_r > 12'(MAX_COLUMNS)) eff_cols = 12'(MAX_COLUMNS);
    else                                                     eff_cols = cols_cfg_r;
    if (chars_cfg_r == 5'd0)                   eff_chars = 5'd1;
    else if (chars_cfg_r > 5'(MAX_CHARS))      eff_chars = 5'(MAX_CHARS);
    else                                       eff_chars = chars_cfg_r;
  end

  // Byte decode for the load
  assign cnt3 = in_code_byte[6:4];
  assign cnt7 = in_code_byte[6:0];
  assign sts.starts_run = await_r ? 1'b1
                        : (in_code_byte[7] ? (cnt7 != 7'd0) : (cnt3 != 3'd0));

  // Chunk: pixels up to the next group boundary or the end of the run
  assign ofs     = row_r[2:0];
  assign grp     = row_r[ROW_W-1:3];
  assign space   = 4'd8 - {1'b0, ofs};
  assign chunk   = (run_r < {5'd0, space}) ? run_r[3:0] : space;
  assign ofs_end = {1'b0, ofs} + chunk;
  assign run_after = run_r - {5'd0, chunk};
  assign row_sum = {1'b0, row_r} + (ROW_W + 1)'(chunk);
  assign old_word = strip_r[grp];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (!keep_r && (4'(i) >= {1'b0, ofs}) && (4'(i) < ofs_end))
        new_word[4*i +: 4] = color_r;
      else
        new_word[4*i +: 4] = old_word[4*i +: 4];
    end
  end

  assign boundary = (row_sum[2:0] == 3'd0);
  assign col_end  = boundary && (row_sum >= (ROW_W + 1)'({eff_chars, 3'b000}));
  assign col_inc  = {1'b0, col_r} + 12'd1;
  assign img_done = col_end && (col_inc >= eff_cols);

  assign col_chars = col_r[10:3] * eff_chars;
  assign grp_addr  = {1'b0, base_r} + {2'b00, col_chars, 6'd0}
                   + 21'({grp, 6'd0}) + {18'd0, col_r[2:0]};

  always_comb begin
    row_nxt = row_sum[ROW_W-1:0];
    col_nxt = col_r;
    run_nxt = run_after;
    if (col_end) begin
      row_nxt = '0;
      col_nxt = col_inc[10:0];
    end
    if (img_done) begin
      col_nxt = '0;
      run_nxt = '0;
    end
  end

  assign can_step       = !out_valid_r || out_ready;
  assign sts.can_step   = can_step;
  assign sts.last_chunk = (run_after == 9'd0) || img_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r  <= 12'd320;
      chars_cfg_r <= 5'd16;
      base_r      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_COLUMNS:   cols_cfg_r  <= cfg_wdata[11:0];
        REG_HEIGHT_IN_CHARS: chars_cfg_r <= cfg_wdata[4:0];
        REG_BASE_ADDRESS:    base_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < MAX_CHARS; g++) strip_r[g] <= '0;
      run_r   <= 9'd1;
      color_r <= '0;
      keep_r  <= 1'b0;
      await_r <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
    end else if (cmd.load) begin
      if (await_r) begin
        await_r <= 1'b0;
        run_r   <= (in_code_byte == 8'd0) ? 9'd256 : {1'b0, in_code_byte};
      end else begin
        keep_r <= in_code_byte[7];
        if (in_code_byte[7]) begin
          run_r   <= {2'b00, cnt7};
          await_r <= (cnt7 == 7'd0);
        end else begin
          run_r   <= {6'd0, cnt3};
          color_r <= in_code_byte[3:0];
          await_r <= (cnt3 == 3'd0);
        end
      end
    end else if (cmd.step) begin
      if (!keep_r) strip_r[grp] <= new_word;
      run_r <= run_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Output register: load a finished group, drop it once the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n)                      out_valid_r <= 1'b0;
    else if (cmd.step && boundary)   out_valid_r <= 1'b1;
    else if (out_ready)              out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.step && boundary) begin
      addr_r   <= grp_addr;
      pix_r    <= new_word;
      colidx_r <= col_r;
      crow_r   <= 4'(grp);
      done_r   <= img_done;
      last_r   <= img_done || (run_after < 9'd8);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_group_address = addr_r;
  assign out_group_pixels  = pix_r;
  assign out_column_index  = colidx_r;
  assign out_char_row      = crow_r;
  assign out_image_done    = done_r;
  assign out_last_of_item  = last_r;

endmodule

// ===== src/rle_column_bitmap_decoder_core.sv =====
// Each byte is taken by a load; its run then expands one chunk per cycle while the
// output register can take a group, a chunk reaching at most the next group of eight
// rows. A group result is registered and shows in the cycle after its chunk.
// Synchronous active-low reset clears the color strip, run state and position, and
// loads register defaults (320 columns, 16 chars).
module rle_column_bitmap_decoder_core import rcbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_group_address,
  output logic [31:0] out_group_pixels,
  output logic [10:0] out_column_index,
  output logic [3:0]  out_char_row,
  output logic        out_image_done,
  output logic        out_last_of_item
);

  cmd_t cmd;
  sts_t sts;

  rcbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcbd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_code_byte      (in_code_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_group_address (out_group_address),
    .out_group_pixels  (out_group_pixels),
    .out_column_index  (out_column_index),
    .out_char_row      (out_char_row),
    .out_image_done    (out_image_done),
    .out_last_of_item  (out_last_of_item)
  );

  // The final group of an image always closes its byte
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_last_of_item)
    else $error("image_done without last_of_item");

  // More groups of the same byte are pending, so no new byte may be taken
  a_no_accept_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_item |-> !in_ready)
    else $error("input ready while a byte still has groups to emit");

  // Loading a byte and stepping a run never happen together
  a_load_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step in the same cycle");

endmodule
